[design/csg_pkg.sv]
// ----------------------------------------------------------------------------
// csg_pkg : shared types and constants of the compressor surge guard
// Configuration bundle, job classification flags, register indexes,
// fixed constants of the margin arithmetic and the state encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package csg_pkg;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_LINE_SLOPE     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_INTERCEPT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_MARGIN     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_VALVE_GAIN     = 3'd4;

	localparam logic signed [15:0] RST_LINE_SLOPE     = 16'sd256;
	localparam logic signed [15:0] RST_LINE_INTERCEPT = 16'sd0;
	localparam logic [12:0]        RST_MIN_MARGIN     = 13'd640;
	localparam logic [15:0]        RST_SAMPLE_PERIOD  = 16'd10;
	localparam logic [11:0]        RST_VALVE_GAIN     = 12'd256;

	// margin arithmetic
	localparam logic signed [15:0] MARGIN_FULL    = 16'sd6400;
	localparam logic signed [15:0] MARGIN_ZERO    = 16'sd0;
	localparam logic signed [15:0] MARGIN_MAX     = 16'sd32767;
	localparam logic signed [15:0] MARGIN_MIN     = -16'sd32768;
	localparam int                 QUOT_BITS      = 17;
	localparam logic [13:0]        SETPOINT_FLOOR = 14'd640;
	localparam logic [12:0]        VALVE_MAX      = 13'd6400;

	// job queue
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic signed [15:0] slope;
		logic signed [15:0] intercept;
		logic [12:0]        min_margin;
		logic [15:0]        period;
		logic [11:0]        gain;
	} cfg_t;

	// classification made at the front
	typedef struct packed {
		logic prev_pos;   // previous flow above zero
		logic reverse;    // flow not above zero while dp above zero
	} cls_t;

	typedef enum logic [3:0] {
		M_IDLE,
		M_SQ,
		M_LO,
		M_HI,
		M_LINE,
		M_DIFF,
		M_NUM,
		M_SAT,
		M_DIV,
		M_FIN,
		M_DONE
	} mstate_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_CUR,
		B_PREV,
		B_DECIDE,
		B_OUT
	} bstate_t;

endpackage

`default_nettype wire

[design/csg_margin.sv]
// ----------------------------------------------------------------------------
// csg_margin : iterative surge margin unit
// Forms the surge line slope*f^2 + intercept over a few multiply stages,
// scales the pressure gap by 6400 and divides one quotient bit per cycle,
// saturating the result to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module csg_margin #(
	parameter int W = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire logic signed [W-1:0] flow,
	input  wire logic signed [W-1:0] pressure,
	input  wire logic signed [15:0] slope,
	input  wire logic signed [15:0] intercept,
	output logic                    done,
	output logic signed [15:0]      result
);

	localparam int PW = W + 17;          // slope times half of f^2
	localparam int LW = 2 * W + 17;      // surge line
	localparam int DW = LW + 1;          // line minus dp
	localparam int NW = DW + 13;         // scaled by 6400
	localparam int RW = LW + csg_pkg::QUOT_BITS;

	csg_pkg::mstate_t state_q, state_d;

	logic [W-1:0]           f_q;
	logic signed [W-1:0]    d_q;
	logic [2*W-1:0]         fsq_q;
	logic signed [PW-1:0]   plo_q, phi_q;
	logic signed [LW-1:0]   line_q;
	logic signed [DW-1:0]   diff_q;
	logic [RW-1:0]          rem_q, dv_q;
	logic                   neg_q;
	logic [csg_pkg::QUOT_BITS-1:0] quot_q;
	logic [4:0]             step_q;
	logic signed [15:0]     res_q;

	logic [2*W-1:0]         fsq_c;
	logic signed [PW-1:0]   plo_c, phi_c;
	logic signed [LW-1:0]   line_c;
	logic signed [DW-1:0]   diff_c;
	logic signed [NW-1:0]   num_c;
	logic [NW-1:0]          mag_c;
	logic [RW-1:0]          lim_c;
	logic                   flow_pos, line_pos, sat_c, fit_c;
	logic [csg_pkg::QUOT_BITS:0] negq_c;
	logic signed [15:0]     fin_c;

	function automatic logic signed [15:0] num_sign_sat(input logic neg);
		num_sign_sat = neg ? csg_pkg::MARGIN_MIN : csg_pkg::MARGIN_MAX;
	endfunction

	assign fsq_c  = (2*W)'(f_q) * (2*W)'(f_q);
	assign plo_c  = PW'(slope) * PW'($signed({1'b0, fsq_q[W-1:0]}));
	assign phi_c  = PW'(slope) * PW'($signed({1'b0, fsq_q[2*W-1:W]}));
	assign line_c = (LW'(phi_q) <<< W) + LW'(plo_q) + (LW'(intercept) <<< 16);
	assign diff_c = DW'(line_q) - (DW'(d_q) <<< 16);
	// 6400 = 4096 + 2048 + 256
	assign num_c  = (NW'(diff_q) <<< 12) + (NW'(diff_q) <<< 11) + (NW'(diff_q) <<< 8);
	assign mag_c  = num_c[NW-1] ? $unsigned(-num_c) : $unsigned(num_c);
	assign lim_c  = {{(RW-LW){1'b0}}, line_q} << csg_pkg::QUOT_BITS;

	assign flow_pos = (flow > $signed(W'(0)));
	assign line_pos = (line_q > $signed(LW'(0)));
	assign sat_c    = (rem_q >= lim_c);
	assign fit_c    = (rem_q >= dv_q);
	assign negq_c   = -{1'b0, quot_q};

	always_comb begin
		if (neg_q) begin
			if (quot_q > csg_pkg::QUOT_BITS'(32768)) begin
				fin_c = csg_pkg::MARGIN_MIN;
			end else begin
				fin_c = $signed(negq_c[15:0]);
			end
		end else begin
			if (quot_q > csg_pkg::QUOT_BITS'(32767)) begin
				fin_c = csg_pkg::MARGIN_MAX;
			end else begin
				fin_c = $signed(quot_q[15:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csg_pkg::M_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			csg_pkg::M_IDLE: begin
				if (start) begin
					state_d = flow_pos ? csg_pkg::M_SQ : csg_pkg::M_DONE;
				end
			end
			csg_pkg::M_SQ:   state_d = csg_pkg::M_LO;
			csg_pkg::M_LO:   state_d = csg_pkg::M_HI;
			csg_pkg::M_HI:   state_d = csg_pkg::M_LINE;
			csg_pkg::M_LINE: state_d = csg_pkg::M_DIFF;
			csg_pkg::M_DIFF: state_d = line_pos ? csg_pkg::M_NUM : csg_pkg::M_DONE;
			csg_pkg::M_NUM:  state_d = csg_pkg::M_SAT;
			csg_pkg::M_SAT:  state_d = sat_c ? csg_pkg::M_DONE : csg_pkg::M_DIV;
			csg_pkg::M_DIV: begin
				if (step_q == 5'd0) begin
					state_d = csg_pkg::M_FIN;
				end
			end
			csg_pkg::M_FIN:  state_d = csg_pkg::M_DONE;
			csg_pkg::M_DONE: begin
				// chain straight into the next margin when asked
				if (start) begin
					state_d = flow_pos ? csg_pkg::M_SQ : csg_pkg::M_DONE;
				end else begin
					state_d = csg_pkg::M_IDLE;
				end
			end
			default:         state_d = csg_pkg::M_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			csg_pkg::M_IDLE, csg_pkg::M_DONE: begin
				f_q   <= flow;
				d_q   <= pressure;
				res_q <= csg_pkg::MARGIN_ZERO;
			end
			csg_pkg::M_SQ:   fsq_q  <= fsq_c;
			csg_pkg::M_LO:   plo_q  <= plo_c;
			csg_pkg::M_HI:   phi_q  <= phi_c;
			csg_pkg::M_LINE: line_q <= line_c;
			csg_pkg::M_DIFF: begin
				diff_q <= diff_c;
				res_q  <= csg_pkg::MARGIN_FULL;
			end
			csg_pkg::M_NUM: begin
				rem_q <= {{(RW-NW){1'b0}}, mag_c};
				neg_q <= num_c[NW-1];
			end
			csg_pkg::M_SAT: begin
				res_q  <= num_sign_sat(neg_q);
				dv_q   <= lim_c >> 1;
				quot_q <= '0;
				step_q <= 5'(csg_pkg::QUOT_BITS - 1);
			end
			csg_pkg::M_DIV: begin
				// one quotient bit per cycle
				if (fit_c) begin
					rem_q <= rem_q - dv_q;
				end
				quot_q <= {quot_q[csg_pkg::QUOT_BITS-2:0], fit_c};
				dv_q   <= dv_q >> 1;
				step_q <= step_q - 5'd1;
			end
			csg_pkg::M_FIN:  res_q <= fin_c;
			default: ;
		endcase
	end

	assign done   = (state_q == csg_pkg::M_DONE);
	assign result = res_q;

	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == csg_pkg::M_DIV) |-> (step_q < 5'(csg_pkg::QUOT_BITS)))
		else $error("divider step count out of range");

endmodule

`default_nettype wire

[design/csg_queue.sv]
// ----------------------------------------------------------------------------
// csg_queue : short job queue between front and back
// Two-entry register queue; lets the front take a new sample while the
// back is still working on the previous one.
// ----------------------------------------------------------------------------
`default_nettype none

module csg_queue #(
	parameter int WIDTH = 50
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire [WIDTH-1:0]  push_data,
	output logic             full,
	input  wire              pop,
	output logic [WIDTH-1:0] head,
	output logic             empty
);

	localparam int DEPTH = csg_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop && !empty) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(empty || full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

[design/csg_front.sv]
// ----------------------------------------------------------------------------
// csg_front : sample intake and classification
// Accepts samples, pairs each with the previous flow, classifies reverse
// flow and previous-flow sign, and pushes the job into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module csg_front #(
	parameter int W = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire logic signed [W-1:0] flow_sample,
	input  wire logic signed [W-1:0] pressure_sample,
	input  wire                      q_full,
	output logic                     q_push,
	output logic [3*W+$bits(csg_pkg::cls_t)-1:0] q_data
);

	logic signed [W-1:0] last_flow_q;
	csg_pkg::cls_t       cls;

	assign cls.prev_pos = (last_flow_q > $signed(W'(0)));
	assign cls.reverse  = (flow_sample <= $signed(W'(0))) &&
	                      (pressure_sample > $signed(W'(0)));

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;
	assign q_data   = {flow_sample, pressure_sample, last_flow_q, cls};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_flow_q <= '0;
		end else if (q_push) begin
			last_flow_q <= flow_sample;
		end
	end

endmodule

`default_nettype wire

[design/csg_back.sv]
// ----------------------------------------------------------------------------
// csg_back : margin evaluation, surge decision and valve command
// Pops jobs, runs the margin unit for the current flow and, when the rate
// check applies, for the previous flow; then decides, updates the latch
// and loads the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csg_back #(
	parameter int W = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire csg_pkg::cfg_t  cfg,
	input  wire                 q_empty,
	input  wire [3*W+$bits(csg_pkg::cls_t)-1:0] q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic signed [15:0]  margin,
	output logic                override_active,
	output logic                surge_flag,
	output logic [12:0]         valve_position
);

	localparam int CW = $bits(csg_pkg::cls_t);

	csg_pkg::bstate_t state_q, state_d;

	logic signed [W-1:0] head_flow, head_press, head_prev;
	csg_pkg::cls_t       head_cls;

	logic signed [W-1:0] press_q, prev_q;
	csg_pkg::cls_t       cls_q;
	logic signed [15:0]  m_q, pm_q;
	logic                rate_chk_q;
	logic signed [30:0]  prod_q;
	logic                ovr_q, latch_nxt_q, latch_q;

	logic                m_start, m_done;
	logic signed [W-1:0] m_flow, m_press;
	logic signed [15:0]  m_res;
	logic                go_prev, below_min, slot_free;

	logic                min_trip, rate_trip, below2, fall_fast;
	logic signed [21:0]  dm, per5;
	logic [13:0]         twice_min, setpoint;
	logic signed [17:0]  err;
	logic signed [30:0]  prod_c;
	logic [22:0]         vraw;
	logic [12:0]         valve_c;

	assign {head_flow, head_press, head_prev} = q_head[3*W+CW-1:CW];
	assign head_cls = q_head[CW-1:0];

	assign below_min = ($signed({m_res[15], m_res}) < $signed({4'b0, cfg.min_margin}));
	assign go_prev   = !below_min && (cfg.period != '0) && cls_q.prev_pos;
	assign slot_free = !out_valid || !out_stall;

	assign q_pop   = (state_q == csg_pkg::B_IDLE) && !q_empty;
	assign m_start = q_pop || ((state_q == csg_pkg::B_CUR) && m_done && go_prev);
	assign m_flow  = (state_q == csg_pkg::B_IDLE) ? head_flow  : prev_q;
	assign m_press = (state_q == csg_pkg::B_IDLE) ? head_press : press_q;

	csg_margin #(.W(W)) u_margin (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (m_start),
		.flow      (m_flow),
		.pressure  (m_press),
		.slope     (cfg.slope),
		.intercept (cfg.intercept),
		.done      (m_done),
		.result    (m_res)
	);

	// decision terms
	assign min_trip  = ($signed({m_q[15], m_q}) < $signed({4'b0, cfg.min_margin}));
	assign dm        = 22'(m_q) - 22'(pm_q);
	assign per5      = $signed({6'b0, cfg.period} + ({6'b0, cfg.period} << 2));
	assign fall_fast = ((dm <<< 4) < -per5);
	assign below2    = ($signed({m_q[15], m_q}) < $signed({3'b0, cfg.min_margin, 1'b0}));
	assign rate_trip = rate_chk_q && fall_fast && below2;

	assign twice_min = {cfg.min_margin, 1'b0};
	assign setpoint  = (twice_min < csg_pkg::SETPOINT_FLOOR) ? csg_pkg::SETPOINT_FLOOR
	                                                          : twice_min;
	assign err       = $signed({4'b0, setpoint}) - 18'(m_q);
	assign prod_c    = 31'($signed({1'b0, cfg.gain})) * 31'(err);

	// floor divide by 256, clamp to full open, shut if period or product <= 0
	assign vraw = prod_q[30:8];
	always_comb begin
		if ((cfg.period == '0) || (prod_q <= 31'sd0)) begin
			valve_c = '0;
		end else if (vraw > 23'(csg_pkg::VALVE_MAX)) begin
			valve_c = csg_pkg::VALVE_MAX;
		end else begin
			valve_c = vraw[12:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csg_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			csg_pkg::B_IDLE: begin
				if (!q_empty) begin
					state_d = csg_pkg::B_CUR;
				end
			end
			csg_pkg::B_CUR: begin
				if (m_done) begin
					state_d = go_prev ? csg_pkg::B_PREV : csg_pkg::B_DECIDE;
				end
			end
			csg_pkg::B_PREV: begin
				if (m_done) begin
					state_d = csg_pkg::B_DECIDE;
				end
			end
			csg_pkg::B_DECIDE: state_d = csg_pkg::B_OUT;
			csg_pkg::B_OUT: begin
				if (slot_free) begin
					state_d = csg_pkg::B_IDLE;
				end
			end
			default: state_d = csg_pkg::B_IDLE;
		endcase
	end

	// job payload and intermediate results
	always_ff @(posedge clk) begin
		case (state_q)
			csg_pkg::B_IDLE: begin
				press_q <= head_press;
				prev_q  <= head_prev;
				cls_q   <= head_cls;
			end
			csg_pkg::B_CUR: begin
				if (m_done) begin
					m_q        <= m_res;
					rate_chk_q <= go_prev;
				end
			end
			csg_pkg::B_PREV: begin
				if (m_done) begin
					pm_q <= m_res;
				end
			end
			csg_pkg::B_DECIDE: begin
				prod_q <= prod_c;
				if (min_trip) begin
					ovr_q       <= 1'b1;
					latch_nxt_q <= 1'b1;
				end else if (rate_trip) begin
					// rate trip without a minimum trip keeps the latch, even on reverse flow
					ovr_q       <= 1'b1;
					latch_nxt_q <= latch_q;
				end else if (cls_q.reverse) begin
					ovr_q       <= 1'b1;
					latch_nxt_q <= 1'b1;
				end else begin
					ovr_q       <= 1'b0;
					latch_nxt_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	// output register and surge latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			latch_q   <= 1'b0;
		end else if ((state_q == csg_pkg::B_OUT) && slot_free) begin
			out_valid <= 1'b1;
			latch_q   <= latch_nxt_q;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == csg_pkg::B_OUT) && slot_free) begin
			margin          <= m_q;
			override_active <= ovr_q;
			surge_flag      <= latch_nxt_q;
			valve_position  <= valve_c;
		end
	end

	a_flag_needs_override: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !override_active) |-> !surge_flag)
		else $error("surge flag set without override");

	a_valve_off_no_period: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (cfg.period == '0)) |-> (valve_position == '0))
		else $error("valve open with zero sample period");

	a_margin_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		m_done |-> ((state_q == csg_pkg::B_CUR) || (state_q == csg_pkg::B_PREV)))
		else $error("margin result arrived while not waiting for it");

endmodule

`default_nettype wire

[design/compressor_surge_guard.sv]
// ----------------------------------------------------------------------------
// compressor_surge_guard : surge margin, detection and recycle valve command
// Each flow/differential-pressure beat yields one result beat with the
// surge margin, the override and latched surge flags and the valve
// opening. Samples go through a two-entry queue into a back end that works
// on one sample at a time; its cost is set by the shared margin unit,
// which runs multiply stages and then a 17-step restoring divider, cut
// short when the flow or the surge line is not above zero or the
// quotient saturates. Without the rate check the unit runs once per
// sample; with it (nonzero period, previous flow above zero, margin not
// under the minimum) it runs twice back to back. A stalled result holds
// the back end until it is taken. The front keeps taking beats while the
// queue has room, and a finished result waits in the output register.
// Configuration is written through cfg_we/cfg_index/cfg_data. The user
// must write it only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module compressor_surge_guard #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire                                          clk,
	input  wire                                          arst_n,
	input  wire                                          cfg_we,
	input  wire [csg_pkg::CFG_INDEX_W-1:0]               cfg_index,
	input  wire [csg_pkg::CFG_DATA_W-1:0]                cfg_data,
	input  wire                                          in_valid,
	output logic                                         in_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0]          flow_sample,
	input  wire logic signed [SAMPLE_WIDTH-1:0]          pressure_sample,
	output logic                                         out_valid,
	input  wire                                          out_stall,
	output logic signed [15:0]                           margin,
	output logic                                         override_active,
	output logic                                         surge_flag,
	output logic [12:0]                                  valve_position
);

	localparam int JW = 3 * SAMPLE_WIDTH + $bits(csg_pkg::cls_t);

	csg_pkg::cfg_t cfg_q;

	logic          q_push, q_full, q_pop, q_empty;
	logic [JW-1:0] q_data, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slope      <= csg_pkg::RST_LINE_SLOPE;
			cfg_q.intercept  <= csg_pkg::RST_LINE_INTERCEPT;
			cfg_q.min_margin <= csg_pkg::RST_MIN_MARGIN;
			cfg_q.period     <= csg_pkg::RST_SAMPLE_PERIOD;
			cfg_q.gain       <= csg_pkg::RST_VALVE_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				csg_pkg::REG_LINE_SLOPE:     cfg_q.slope      <= $signed(cfg_data);
				csg_pkg::REG_LINE_INTERCEPT: cfg_q.intercept  <= $signed(cfg_data);
				csg_pkg::REG_MIN_MARGIN:     cfg_q.min_margin <= cfg_data[12:0];
				csg_pkg::REG_SAMPLE_PERIOD:  cfg_q.period     <= cfg_data;
				csg_pkg::REG_VALVE_GAIN:     cfg_q.gain       <= cfg_data[11:0];
				default: ;  // drop writes past the register list
			endcase
		end
	end

	csg_front #(.W(SAMPLE_WIDTH)) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.flow_sample     (flow_sample),
		.pressure_sample (pressure_sample),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_data          (q_data)
	);

	csg_queue #(.WIDTH(JW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	csg_back #(.W(SAMPLE_WIDTH)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_empty         (q_empty),
		.q_head          (q_head),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.margin          (margin),
		.override_active (override_active),
		.surge_flag      (surge_flag),
		.valve_position  (valve_position)
	);

endmodule

`default_nettype wire
